[rtl/mono_framebuffer_blitter_defines.svh]
// Assertion macros for the monochrome framebuffer blitter.
// No dependencies; included by the top level only.
`ifndef MONO_FRAMEBUFFER_BLITTER_DEFINES_SVH
`define MONO_FRAMEBUFFER_BLITTER_DEFINES_SVH

// same-cycle implication check
`define MFB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication check
`define MFB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/mfb_pkg.sv]
// Shared types and constants for the monochrome framebuffer blitter.
// No dependencies; used by every module of the block.
package mfb_pkg;

   localparam int NUM_COLUMNS_DEF      = 128;
   localparam int SPRITE_MAX_WIDTH_DEF = 8;
   localparam int SPRITE_BITS_DEF      = 8;
   localparam int COLUMN_BITS          = 32;
   localparam int BYTE_BITS            = 8;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_BLIT   = 2'd1,
      FUNC_INVERT = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

endpackage

[rtl/mfb_store.sv]
// Column store: one write port, one read port with registered read data.
// Depends on mfb_pkg for the column width.
module mfb_store #(
   parameter int NUM_COLUMNS = mfb_pkg::NUM_COLUMNS_DEF,
   localparam int AddrBits = $clog2(NUM_COLUMNS)
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [AddrBits-1:0]             rd_addr,
   output logic [mfb_pkg::COLUMN_BITS-1:0] rd_data,
   input  logic                            wr_en,
   input  logic [AddrBits-1:0]             wr_addr,
   input  logic [mfb_pkg::COLUMN_BITS-1:0] wr_data
);

   logic [mfb_pkg::COLUMN_BITS-1:0] mem [NUM_COLUMNS];
   logic [mfb_pkg::COLUMN_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mfb_ctrl.sv]
// Sequencer for clear, blit, invert and read; read-modify-write of the store.
// Depends on mfb_pkg; drives the ports of mfb_store.
module mfb_ctrl #(
   parameter int NUM_COLUMNS      = mfb_pkg::NUM_COLUMNS_DEF,
   parameter int SPRITE_MAX_WIDTH = mfb_pkg::SPRITE_MAX_WIDTH_DEF,
   parameter int SPRITE_BITS      = mfb_pkg::SPRITE_BITS_DEF,
   localparam int AddrBits = $clog2(NUM_COLUMNS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic signed [8:0]               req_x_pos,
   input  logic signed [5:0]               req_y_shift,
   input  logic [3:0]                      req_sprite_width,
   input  logic [63:0]                     req_sprite_columns,
   input  logic [1:0]                      req_page,
   output logic                            res_valid,
   input  logic                            res_free,
   output logic [mfb_pkg::BYTE_BITS-1:0]   res_byte,
   output logic                            mem_rd_en,
   output logic [AddrBits-1:0]             mem_rd_addr,
   input  logic [mfb_pkg::COLUMN_BITS-1:0] mem_rd_data,
   output logic                            mem_wr_en,
   output logic [AddrBits-1:0]             mem_wr_addr,
   output logic [mfb_pkg::COLUMN_BITS-1:0] mem_wr_data
);

   localparam logic [7:0] BitMask = 8'((16'd1 << SPRITE_BITS) - 16'd1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INVERT,
      ST_BLIT,
      ST_READ,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   function automatic logic [31:0] shift_col(input logic [31:0] col,
                                             input logic signed [5:0] sh);
      logic [5:0] mag;
      mag = 6'(-sh);
      if (!sh[5]) begin
         return col << sh[4:0];
      end else if (mag[5]) begin
         return '0;
      end else begin
         return col >> mag[4:0];
      end
   endfunction

   state_type                       state_ff, state_in;
   logic [AddrBits-1:0]             cnt_ff, cnt_in;
   logic [3:0]                      k_ff, k_in;
   logic [3:0]                      width_ff, width_in;
   logic signed [8:0]               x_ff, x_in;
   logic signed [5:0]               sh_ff, sh_in;
   logic [63:0]                     sprite_ff, sprite_in;
   logic [1:0]                      page_ff, page_in;
   logic                            pend_ff, pend_in;
   logic                            pend_inv_ff, pend_inv_in;
   logic [AddrBits-1:0]             pend_addr_ff, pend_addr_in;
   logic [mfb_pkg::COLUMN_BITS-1:0] or_data_ff, or_data_in;
   logic                            in_range_ff, in_range_in;

   logic [9:0]                      col_s;
   logic                            col_ok;
   logic [AddrBits-1:0]             col_addr;
   logic [7:0]                      spr_byte;
   logic                            sweep_last;
   logic [3:0]                      k_next;

   assign col_s      = {x_ff[8], x_ff} + {6'd0, k_ff};
   assign col_ok     = !col_s[9] && (32'(col_s[8:0]) < NUM_COLUMNS);
   assign col_addr   = AddrBits'(col_s[8:0]);
   assign spr_byte   = sprite_ff[{k_ff[2:0], 3'b000} +: 8] & BitMask;
   assign sweep_last = (cnt_ff == AddrBits'(NUM_COLUMNS - 1));
   assign k_next     = k_ff + 4'd1;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      width_in     = width_ff;
      x_in         = x_ff;
      sh_in        = sh_ff;
      sprite_in    = sprite_ff;
      page_in      = page_ff;
      pend_in      = 1'b0;
      pend_inv_in  = 1'b0;
      pend_addr_in = pend_addr_ff;
      or_data_in   = or_data_ff;
      in_range_in  = in_range_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = cnt_ff;
      res_valid    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + AddrBits'(1);
            if (sweep_last) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               x_in      = req_x_pos;
               sh_in     = req_y_shift;
               sprite_in = req_sprite_columns;
               page_in   = req_page;
               cnt_in    = '0;
               k_in      = '0;
               width_in  = (req_sprite_width > SPRITE_MAX_WIDTH) ?
                           4'(SPRITE_MAX_WIDTH) : req_sprite_width;
               case (mfb_pkg::func_type'(req_func))
                  mfb_pkg::FUNC_CLEAR:  state_in = ST_CLEAR;
                  mfb_pkg::FUNC_BLIT:   state_in = (width_in == 4'd0) ? ST_DRAIN : ST_BLIT;
                  mfb_pkg::FUNC_INVERT: state_in = ST_INVERT;
                  mfb_pkg::FUNC_READ:   state_in = ST_READ;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_INVERT: begin
            mem_rd_en    = 1'b1;
            pend_in      = 1'b1;
            pend_inv_in  = 1'b1;
            pend_addr_in = cnt_ff;
            cnt_in       = cnt_ff + AddrBits'(1);
            if (sweep_last) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_BLIT: begin
            mem_rd_addr = col_addr;
            if (col_ok) begin
               mem_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = col_addr;
               or_data_in   = shift_col(32'(spr_byte), sh_ff);
            end
            k_in = k_next;
            if (k_next == width_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_READ: begin
            mem_rd_addr = col_addr;
            mem_rd_en   = col_ok;
            in_range_in = col_ok;
            state_in    = ST_RESULT;
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         ST_RESULT: begin
            res_valid = 1'b1;
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      res_byte  = in_range_ff ? mem_rd_data[{page_ff, 3'b000} +: 8] : 8'd0;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = cnt_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = pend_ff;
         mem_wr_addr = pend_addr_ff;
         mem_wr_data = pend_inv_ff ? ~mem_rd_data : (mem_rd_data | or_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      k_ff         <= k_in;
      width_ff     <= width_in;
      x_ff         <= x_in;
      sh_ff        <= sh_in;
      sprite_ff    <= sprite_in;
      page_ff      <= page_in;
      pend_inv_ff  <= pend_inv_in;
      pend_addr_ff <= pend_addr_in;
      or_data_ff   <= or_data_in;
      in_range_ff  <= in_range_in;
   end

endmodule

[rtl/mono_framebuffer_blitter.sv]
// Top level of the monochrome framebuffer blitter: sequencer, store, result register.
// Depends on mfb_pkg, mfb_store, mfb_ctrl and mono_framebuffer_blitter_defines.svh.
//
//   channel | ports             | carries
//   --------+-------------------+----------------------------------------
//   req     | req_valid/ready   | func, x_pos, y_shift, sprite_width, ...
//   rsp     | rsp_valid/ready   | read_byte, one per read item
//
// One item at a time. Blit reads one column per cycle through the store's
// single read port; invert and clear sweep every column, and read waits for
// any hold on the result register. After reset a clearing pass runs before
// req_ready rises. A held result stalls only a later read item, in its
// result state.
`include "mono_framebuffer_blitter_defines.svh"

module mono_framebuffer_blitter #(
   parameter int NUM_COLUMNS      = mfb_pkg::NUM_COLUMNS_DEF,
   parameter int SPRITE_MAX_WIDTH = mfb_pkg::SPRITE_MAX_WIDTH_DEF,
   parameter int SPRITE_BITS      = mfb_pkg::SPRITE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [8:0]             req_x_pos,
   input  logic signed [5:0]             req_y_shift,
   input  logic [3:0]                    req_sprite_width,
   input  logic [63:0]                   req_sprite_columns,
   input  logic [1:0]                    req_page,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mfb_pkg::BYTE_BITS-1:0] rsp_read_byte
);

   localparam int AddrBits = $clog2(NUM_COLUMNS);

   logic                            res_valid;
   logic                            res_free;
   logic [mfb_pkg::BYTE_BITS-1:0]   res_byte;
   logic                            mem_rd_en;
   logic [AddrBits-1:0]             mem_rd_addr;
   logic [mfb_pkg::COLUMN_BITS-1:0] mem_rd_data;
   logic                            mem_wr_en;
   logic [AddrBits-1:0]             mem_wr_addr;
   logic [mfb_pkg::COLUMN_BITS-1:0] mem_wr_data;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mfb_pkg::BYTE_BITS-1:0]   rsp_byte_ff, rsp_byte_in;

   mfb_ctrl #(
      .NUM_COLUMNS      (NUM_COLUMNS),
      .SPRITE_MAX_WIDTH (SPRITE_MAX_WIDTH),
      .SPRITE_BITS      (SPRITE_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_x_pos          (req_x_pos),
      .req_y_shift        (req_y_shift),
      .req_sprite_width   (req_sprite_width),
      .req_sprite_columns (req_sprite_columns),
      .req_page           (req_page),
      .res_valid          (res_valid),
      .res_free           (res_free),
      .res_byte           (res_byte),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data)
   );

   mfb_store #(
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign res_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      if (res_valid && res_free) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

   `MFB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `MFB_ASSERT_IMPLY(a_no_write_when_idle, clock, reset, mem_wr_en, !req_ready)
   `MFB_ASSERT_IMPLY(a_no_rw_same_entry, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)

endmodule
